// File: sv/checkerboard_swap_engine_core_assert.svh
// Assertion macros for the checkerboard swap engine.
// No dependencies; included by the top level.
`ifndef CHECKERBOARD_SWAP_ENGINE_CORE_ASSERT_SVH
`define CHECKERBOARD_SWAP_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cse_pkg.sv
// Package for the checkerboard swap engine: sizes, codes and beat types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

   // matrix geometry and value format
   localparam int MAX_ROWS      = 64;
   localparam int MAX_COLS      = 64;
   localparam int VALUE_BITS    = 16;
   localparam int ROW_BITS      = 6;
   localparam int COL_BITS      = 6;
   localparam int ADDR_BITS     = ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int COUNT_BITS    = 20;
   localparam int USE_BITS      = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_SWAP  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWAP_MODE      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERVAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS_IN_USE    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLS_IN_USE    = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [ROW_BITS-1:0] row_first;
      logic [ROW_BITS-1:0] row_second;
      logic [COL_BITS-1:0] col_first;
      logic [COL_BITS-1:0] col_second;
      logic [15:0]         cell_value;
   } req_beat_type;

   typedef struct packed {
      logic [15:0]           read_value;
      logic                  swapped;
      logic                  rejected;
      logic                  done_res;
      logic [COUNT_BITS-1:0] counted;
   } rsp_beat_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;      // capture the accepted request
      logic       rd_en;      // read cell at idx
      logic       cap_en;     // capture read data into cell slot cap_idx
      logic [1:0] idx;        // cell slot: 0 ik, 1 il, 2 jk, 3 jl
      logic [1:0] cap_idx;
      logic       mem_we;     // write cell at idx
      logic       wr_load;    // write data from request, else swapped partner
      logic       clr_cnt;
      logic       cnt_trial;  // accepted attempt without swap
      logic       cnt_swap;   // successful swap
      logic       respond;
      logic       rsp_rej;
      logic       rsp_sw;
      logic       rsp_rd;     // read_value from read data register
   } cse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cell_ok;     // row_first/col_first in range
      logic attempt_ok;  // all four indices in range, rows distinct and columns distinct
      logic not_done;    // counter below interval
      logic board_hit;   // captured 2x2 is a checkerboard
   } cse_status_type;

endpackage

`default_nettype wire

// File: sv/cse_datapath.sv
// Datapath of the checkerboard swap engine: config registers, cell store,
// captured 2x2 cells, attempt counter and result register. Uses cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [cse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [cse_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire cse_pkg::req_beat_type           req_beat,
   input  wire cse_pkg::cse_cmd_type            cmd,
   output cse_pkg::cse_status_type              status,
   output logic                                 rsp_strobe,
   output cse_pkg::rsp_beat_type                rsp_beat
);
   import cse_pkg::*;

   logic                  swap_mode_ff;
   logic [COUNT_BITS-1:0] interval_ff;
   logic [USE_BITS-1:0]   rows_use_ff;
   logic [USE_BITS-1:0]   cols_use_ff;

   req_beat_type          req_ff;
   logic [VALUE_BITS-1:0] mem_ff [STORE_DEPTH];
   logic [VALUE_BITS-1:0] rdata_ff;
   logic [VALUE_BITS-1:0] cell_ff [4];
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  strobe_ff;
   rsp_beat_type          rsp_ff, rsp_in;

   logic [ADDR_BITS-1:0]  addr;
   logic [VALUE_BITS-1:0] wdata;
   logic                  r1_ok, r2_ok, c1_ok, c2_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_mode_ff <= 1'b0;
         interval_ff  <= '0;
         rows_use_ff  <= USE_BITS'(MAX_ROWS);
         cols_use_ff  <= USE_BITS'(MAX_COLS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SWAP_MODE:      swap_mode_ff <= csr_wdata[0];
            CSR_INTERVAL_COUNT: interval_ff  <= csr_wdata[COUNT_BITS-1:0];
            CSR_ROWS_IN_USE:    rows_use_ff  <= csr_wdata[USE_BITS-1:0];
            CSR_COLS_IN_USE:    cols_use_ff  <= csr_wdata[USE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_beat;
   end

   // index range checks
   always_comb begin
      r1_ok = ({1'b0, req_ff.row_first}  < rows_use_ff) &&
              ({1'b0, req_ff.row_first}  < USE_BITS'(MAX_ROWS));
      r2_ok = ({1'b0, req_ff.row_second} < rows_use_ff) &&
              ({1'b0, req_ff.row_second} < USE_BITS'(MAX_ROWS));
      c1_ok = ({1'b0, req_ff.col_first}  < cols_use_ff) &&
              ({1'b0, req_ff.col_first}  < USE_BITS'(MAX_COLS));
      c2_ok = ({1'b0, req_ff.col_second} < cols_use_ff) &&
              ({1'b0, req_ff.col_second} < USE_BITS'(MAX_COLS));
   end

   // cell address by slot; row-major with a power-of-two row pitch
   always_comb begin
      unique case (cmd.idx)
         2'd0:    addr = {req_ff.row_first,  req_ff.col_first};
         2'd1:    addr = {req_ff.row_first,  req_ff.col_second};
         2'd2:    addr = {req_ff.row_second, req_ff.col_first};
         default: addr = {req_ff.row_second, req_ff.col_second};
      endcase
   end

   // each slot takes its row partner: ik<-jk, il<-jl and back
   assign wdata = cmd.wr_load ? req_ff.cell_value[VALUE_BITS-1:0]
                              : cell_ff[cmd.idx ^ 2'd2];

   // cell store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_we) mem_ff[addr] <= wdata;
      if (cmd.rd_en)  rdata_ff <= mem_ff[addr];
   end

   // captured 2x2 submatrix
   always_ff @(posedge clock) begin
      if (cmd.cap_en) cell_ff[cmd.cap_idx] <= rdata_ff;
   end

   // status to controller
   always_comb begin
      status.cell_ok    = r1_ok && c1_ok;
      status.attempt_ok = r1_ok && r2_ok && c1_ok && c2_ok &&
                          (req_ff.row_first != req_ff.row_second) &&
                          (req_ff.col_first != req_ff.col_second);
      status.not_done   = cnt_ff < interval_ff;
      status.board_hit  =
         ((cell_ff[0] != '0) && (cell_ff[3] != '0) &&
          (cell_ff[1] == '0) && (cell_ff[2] == '0)) ||
         ((cell_ff[0] == '0) && (cell_ff[3] == '0) &&
          (cell_ff[1] != '0) && (cell_ff[2] != '0));
   end

   // attempt counter next value
   always_comb begin
      if (cmd.clr_cnt)
         cnt_in = '0;
      else if (cmd.cnt_swap || (cmd.cnt_trial && !swap_mode_ff))
         cnt_in = cnt_ff + COUNT_BITS'(1);
      else
         cnt_in = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   // result beat, reported against the updated counter
   always_comb begin
      rsp_in.read_value = cmd.rsp_rd ? 16'(rdata_ff) : 16'd0;
      rsp_in.swapped    = cmd.rsp_sw;
      rsp_in.rejected   = cmd.rsp_rej;
      rsp_in.done_res   = cnt_in >= interval_ff;
      rsp_in.counted    = (cnt_in < interval_ff) ? cnt_in : interval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= cmd.respond;
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_beat   = rsp_ff;

endmodule

`default_nettype wire

// File: sv/cse_ctrl.sv
// Controller of the checkerboard swap engine: sequences decode, cell reads,
// checkerboard evaluation, write-back and the result. Uses cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              req_type,
   input  wire cse_pkg::cse_status_type status,
   output logic                         busy,
   output cse_pkg::cse_cmd_type         cmd
);
   import cse_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_RD     = 3'd2;
   localparam logic [2:0] ST_CAP    = 3'd3;
   localparam logic [2:0] ST_EVAL   = 3'd4;
   localparam logic [2:0] ST_WR     = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] type_ff, type_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] last_idx;
   logic       is_read;

   assign is_read  = type_ff == REQ_READ;
   assign last_idx = is_read ? 2'd0 : 2'd3;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      type_in  = type_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               type_in   = req_type;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            idx_in  = 2'd0;
            cmd.idx = 2'd0;
            unique case (type_ff)
               REQ_LOAD: begin
                  cmd.mem_we  = status.cell_ok;
                  cmd.wr_load = 1'b1;
                  cmd.respond = 1'b1;
                  cmd.rsp_rej = !status.cell_ok;
                  state_in    = ST_IDLE;
               end
               REQ_CLEAR: begin
                  cmd.clr_cnt = 1'b1;
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
               REQ_READ: begin
                  if (status.cell_ok) begin
                     state_in = ST_RD;
                  end else begin
                     cmd.respond = 1'b1;
                     cmd.rsp_rej = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  // swap attempt; ignored entirely once done
                  if (!status.not_done) begin
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end else if (!status.attempt_ok) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_rej = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     state_in = ST_RD;
                  end
               end
            endcase
         end
         ST_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.cap_en  = idx_ff != 2'd0;
            cmd.cap_idx = idx_ff - 2'd1;
            if (idx_ff == last_idx) state_in = ST_CAP;
            else                    idx_in   = idx_ff + 2'd1;
         end
         ST_CAP: begin
            if (is_read) begin
               cmd.respond = 1'b1;
               cmd.rsp_rd  = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.cap_en  = 1'b1;
               cmd.cap_idx = 2'd3;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            idx_in = 2'd0;
            if (status.board_hit) begin
               state_in = ST_WR;
            end else begin
               cmd.cnt_trial = 1'b1;
               cmd.respond   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_WR: begin
            cmd.mem_we = 1'b1;
            if (idx_ff == 2'd3) state_in = ST_RESP;
            else                idx_in   = idx_ff + 2'd1;
         end
         ST_RESP: begin
            cmd.cnt_swap = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_sw   = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         type_ff  <= REQ_LOAD;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         type_ff  <= type_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

// File: sv/checkerboard_swap_engine_core.sv
// Checkerboard swap engine: abundance matrix with 2x2 checkerboard swaps.
// Top level joining cse_ctrl and cse_datapath; uses cse_pkg.
//
// Request channel: a beat is taken at a rising edge with start high and
// busy low. Every request gives exactly one result beat on rsp_beat,
// marked by rsp_strobe for one cycle; the receiver cannot hold it off.
// Configuration: csr_we writes csr_wdata into register csr_index at once.
// Steps from the accepting edge to the strobe, with the store behind a
// single write port and a registered read port:
//   load, clear, rejected request or ignored attempt: decode, then the result
//   read: decode, one store read and its data register, then the result
//   attempt without swap: decode, four cell reads, capture, evaluate
//   successful swap: as above, plus four write-backs and the result
// busy falls in the cycle of the strobe, so the next request can be taken
// at the edge that ends its predecessor's strobe; the engine works on one
// request at a time.
// Reset clears the controller, the attempt counter and the registers
// (rows and columns in use back to 64); the store keeps its contents and
// a cell must be loaded before it is read or takes part in an attempt.
`timescale 1ns / 1ps
`default_nettype none

module checkerboard_swap_engine_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire cse_pkg::req_beat_type             req_beat,
   output logic                                   rsp_strobe,
   output cse_pkg::rsp_beat_type                  rsp_beat,
   input  wire logic                              csr_we,
   input  wire logic [cse_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [cse_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cse_pkg::*;

`include "checkerboard_swap_engine_core_assert.svh"

   cse_cmd_type    cmd;
   cse_status_type status;

   // sequencer
   cse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_beat.req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // storage and arithmetic
   cse_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_beat   (req_beat),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat)
   );

   // checks
   `CSE_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted beat did not raise busy")
   `CSE_ASSERT_NXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe, "result strobes back to back")
   `CSE_ASSERT_IMP(a_sw_rej, clock, reset, rsp_strobe, !(rsp_beat.swapped && rsp_beat.rejected), "result both swapped and rejected")
   `CSE_ASSERT_IMP(a_rej_zero, clock, reset, rsp_strobe && rsp_beat.rejected, rsp_beat.read_value == 16'd0, "rejected result carries read data")
   `CSE_ASSERT_IMP(a_sw_write, clock, reset, cmd.mem_we && !cmd.wr_load, status.board_hit, "write-back without checkerboard")

endmodule

`default_nettype wire

// File: tb/checkerboard_swap_engine_core_tb.sv
// Testbench for checkerboard_swap_engine_core: a directed table, then random phases
// across several register settings, results checked against predictor or pinned values.
// Depends on cse_pkg and the RTL of the block only.
`timescale 1ns / 1ps
`default_nettype none

module checkerboard_swap_engine_core_tb;
   import cse_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int REPORT_MAX = 10;

   // one row of the directed table
   typedef struct {
      bit           pin;
      req_beat_type beat;
      rsp_beat_type want;
   } table_row_type;

   // typed-in expectation riding along with a sent beat
   typedef struct packed {
      logic         pin;
      rsp_beat_type beat;
   } pinned_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_beat_type             req_beat = '0;
   logic                     rsp_strobe;
   rsp_beat_type             rsp_beat;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SWAP_MODE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predictor state
   logic [VALUE_BITS-1:0] cell_mirror [STORE_DEPTH];
   logic [COUNT_BITS-1:0] attempt_tally;
   logic                  mode_cfg;
   logic [COUNT_BITS-1:0] interval_cfg;
   logic [USE_BITS-1:0]   rows_cfg;
   logic [USE_BITS-1:0]   cols_cfg;

   rsp_beat_type pending_results [$];
   pinned_type   pinned_results [$];
   int           error_count = 0;
   int           idle_cycles = 0;

   // stimulus side
   bit            cell_written [STORE_DEPTH];
   int            gen_rows = MAX_ROWS;
   int            gen_cols = MAX_COLS;
   int            beats_sent = 0;
   bit            no_gap = 1'b0;
   table_row_type dir_table [$];

   checkerboard_swap_engine_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_beat   (req_beat),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit row_in(input logic [ROW_BITS-1:0] r);
      return {1'b0, r} < rows_cfg;
   endfunction

   function automatic bit col_in(input logic [COL_BITS-1:0] c);
      return {1'b0, c} < cols_cfg;
   endfunction

   // apply one request to the mirror and return the result it must give
   function automatic rsp_beat_type apply_request(input req_beat_type b);
      rsp_beat_type          r;
      logic [VALUE_BITS-1:0] ik, il, jk, jl;
      logic [ADDR_BITS-1:0]  a_ik, a_il, a_jk, a_jl;
      bit                    hit;
      r = '0;
      a_ik = {b.row_first, b.col_first};
      a_il = {b.row_first, b.col_second};
      a_jk = {b.row_second, b.col_first};
      a_jl = {b.row_second, b.col_second};
      case (b.req_type)
         REQ_LOAD: begin
            if (row_in(b.row_first) && col_in(b.col_first))
               cell_mirror[a_ik] = b.cell_value;
            else
               r.rejected = 1'b1;
         end
         REQ_READ: begin
            if (row_in(b.row_first) && col_in(b.col_first))
               r.read_value = cell_mirror[a_ik];
            else
               r.rejected = 1'b1;
         end
         REQ_CLEAR: begin
            attempt_tally = '0;
         end
         REQ_SWAP: begin
            // once done, attempts are dropped without effect
            if (attempt_tally < interval_cfg) begin
               if (b.row_first == b.row_second || b.col_first == b.col_second ||
                   !row_in(b.row_first) || !row_in(b.row_second) ||
                   !col_in(b.col_first) || !col_in(b.col_second)) begin
                  r.rejected = 1'b1;
               end else begin
                  ik = cell_mirror[a_ik];
                  il = cell_mirror[a_il];
                  jk = cell_mirror[a_jk];
                  jl = cell_mirror[a_jl];
                  hit = (ik != 0 && jl != 0 && il == 0 && jk == 0) ||
                        (ik == 0 && jl == 0 && il != 0 && jk != 0);
                  if (hit) begin
                     cell_mirror[a_ik] = jk;
                     cell_mirror[a_jk] = ik;
                     cell_mirror[a_il] = jl;
                     cell_mirror[a_jl] = il;
                     r.swapped = 1'b1;
                  end
                  if (!mode_cfg || hit)
                     attempt_tally = attempt_tally + 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.done_res = attempt_tally >= interval_cfg;
      r.counted  = (attempt_tally < interval_cfg) ? attempt_tally : interval_cfg;
      return r;
   endfunction

   task automatic report_error(input string what, input rsp_beat_type want,
                               input rsp_beat_type got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("%0t %s: want rd=%h sw=%b rej=%b done=%b cnt=%0d, got rd=%h sw=%b rej=%b done=%b cnt=%0d",
                  $realtime, what, want.read_value, want.swapped, want.rejected,
                  want.done_res, want.counted, got.read_value, got.swapped,
                  got.rejected, got.done_res, got.counted);
   endtask

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      rsp_beat_type predicted;
      rsp_beat_type want;
      pinned_type   pinned;
      bit           moved;
      moved = 1'b0;
      if (reset) begin
         attempt_tally = '0;
         mode_cfg      = 1'b0;
         interval_cfg  = '0;
         rows_cfg      = USE_BITS'(MAX_ROWS);
         cols_cfg      = USE_BITS'(MAX_COLS);
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SWAP_MODE:      mode_cfg     = csr_wdata[0];
               CSR_INTERVAL_COUNT: interval_cfg = csr_wdata[COUNT_BITS-1:0];
               CSR_ROWS_IN_USE:    rows_cfg     = csr_wdata[USE_BITS-1:0];
               CSR_COLS_IN_USE:    cols_cfg     = csr_wdata[USE_BITS-1:0];
               default: ;
            endcase
         end
         // request beat taken
         if (start && !busy) begin
            predicted = apply_request(req_beat);
            pinned = pinned_results.pop_front();
            pending_results.push_back(pinned.pin ? pinned.beat : predicted);
            moved = 1'b1;
         end
         // result beat
         if (rsp_strobe) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               report_error("unexpected result", '0, rsp_beat);
            end else begin
               want = pending_results.pop_front();
               if (rsp_beat.read_value !== want.read_value ||
                   rsp_beat.swapped    !== want.swapped    ||
                   rsp_beat.rejected   !== want.rejected   ||
                   rsp_beat.done_res   !== want.done_res   ||
                   rsp_beat.counted    !== want.counted)
                  report_error("mismatch", want, rsp_beat);
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   // watchdog: no beat moving for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("checkerboard_swap_engine_core_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_beat_type make_beat(input logic [1:0] kind, input int r1,
                                              input int r2, input int c1, input int c2,
                                              input int val);
      req_beat_type b;
      b.req_type   = kind;
      b.row_first  = ROW_BITS'(r1);
      b.row_second = ROW_BITS'(r2);
      b.col_first  = COL_BITS'(c1);
      b.col_second = COL_BITS'(c2);
      b.cell_value = 16'(val);
      return b;
   endfunction

   function automatic table_row_type dr(input bit pin, input logic [1:0] kind,
                                        input int r1, input int r2, input int c1,
                                        input int c2, input int val, input int rd,
                                        input bit sw, input bit rej, input bit dn,
                                        input int cnt);
      table_row_type t;
      t.pin  = pin;
      t.beat = make_beat(kind, r1, r2, c1, c2, val);
      t.want.read_value = 16'(rd);
      t.want.swapped    = sw;
      t.want.rejected   = rej;
      t.want.done_res   = dn;
      t.want.counted    = COUNT_BITS'(cnt);
      return t;
   endfunction

   function automatic bit in_use(input int r, input int c);
      return r < gen_rows && c < gen_cols;
   endfunction

   // about half zeros so that checkerboards turn up by chance
   function automatic int sparse_value();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick < 4)
         return 0;
      else if (pick == 4)
         return 16'hFFFF;
      return $urandom_range(1, 65535);
   endfunction

   // hold start high with the beat until it is taken
   task automatic send_beat(input req_beat_type b, input bit pin, input rsp_beat_type want);
      int         gap;
      pinned_type p;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p.pin  = pin;
      p.beat = want;
      pinned_results.push_back(p);
      if (b.req_type == REQ_LOAD && in_use(b.row_first, b.col_first))
         cell_written[{b.row_first, b.col_first}] = 1'b1;
      beats_sent++;
      start    <= 1'b1;
      req_beat <= b;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic load_cell(input int r, input int c, input int val);
      send_beat(make_beat(REQ_LOAD, r, $urandom, c, $urandom, val), 1'b0, '0);
   endtask

   // load a cell in use that was never written, so nothing reads undefined data
   task automatic ensure_cell(input int r, input int c);
      if (in_use(r, c) && !cell_written[{6'(r), 6'(c)}])
         load_cell(r, c, sparse_value());
   endtask

   task automatic read_cell(input int r, input int c);
      ensure_cell(r, c);
      send_beat(make_beat(REQ_READ, r, $urandom, c, $urandom, $urandom), 1'b0, '0);
   endtask

   task automatic attempt(input int r1, input int r2, input int c1, input int c2);
      if (r1 != r2 && c1 != c2 && in_use(r1, c1) && in_use(r2, c2)) begin
         ensure_cell(r1, c1);
         ensure_cell(r1, c2);
         ensure_cell(r2, c1);
         ensure_cell(r2, c2);
      end
      send_beat(make_beat(REQ_SWAP, r1, r2, c1, c2, $urandom), 1'b0, '0);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // registers go in only while nothing is in flight
   task automatic set_config(input bit mode, input int interval, input int rows,
                             input int cols);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_SWAP_MODE;
      csr_wdata <= {19'($urandom), mode};
      @(posedge clock);
      csr_index <= CSR_INTERVAL_COUNT;
      csr_wdata <= COUNT_BITS'(interval);
      @(posedge clock);
      csr_index <= CSR_ROWS_IN_USE;
      csr_wdata <= {13'($urandom), 7'(rows)};
      @(posedge clock);
      csr_index <= CSR_COLS_IN_USE;
      csr_wdata <= {13'($urandom), 7'(cols)};
      @(posedge clock);
      csr_we   <= 1'b0;
      gen_rows = rows;
      gen_cols = cols;
   endtask

   // mostly attempts inside the matrix and planted checkerboards, plus noise
   task automatic run_random(input int items);
      int            first, pick;
      int            r1, r2, c1, c2;
      int            ik, il, jk, jl;
      rsp_beat_type  none;
      none  = '0;
      first = beats_sent;
      while (beats_sent - first < items) begin
         if ($urandom_range(0, 29) == 0)
            no_gap = !no_gap;
         pick = $urandom_range(0, 99);
         r1 = $urandom_range(0, gen_rows - 1);
         r2 = (r1 + $urandom_range(1, gen_rows - 1)) % gen_rows;
         c1 = $urandom_range(0, gen_cols - 1);
         c2 = (c1 + $urandom_range(1, gen_cols - 1)) % gen_cols;
         if (pick < 40) begin
            attempt(r1, r2, c1, c2);
         end else if (pick < 55) begin
            // planted checkerboard, diagonal or anti, sometimes spoiled by one cell
            ik = $urandom_range(1, 65535);
            jl = $urandom_range(1, 65535);
            il = 0;
            jk = 0;
            if ($urandom_range(0, 1)) begin
               il = ik;
               jk = jl;
               ik = 0;
               jl = 0;
            end
            if ($urandom_range(0, 3) == 0)
               il = (il == 0) ? $urandom_range(1, 65535) : 0;
            load_cell(r1, c1, ik);
            load_cell(r1, c2, il);
            load_cell(r2, c1, jk);
            load_cell(r2, c2, jl);
            attempt(r1, r2, c1, c2);
            if ($urandom_range(0, 1))
               read_cell(r1, c1);
         end else if (pick < 70) begin
            if ($urandom_range(0, 9) < 7)
               read_cell(r1, c1);
            else
               read_cell($urandom_range(0, 63), $urandom_range(0, 63));
         end else if (pick < 80) begin
            load_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         end else if (pick < 93) begin
            r1 = $urandom_range(0, 63);
            r2 = $urandom_range(0, 63);
            c1 = $urandom_range(0, 63);
            c2 = $urandom_range(0, 63);
            case ($urandom_range(0, 3))
               0: r2 = r1;
               1: c2 = c1;
               default: ;
            endcase
            attempt(r1, r2, c1, c2);
         end else begin
            send_beat(make_beat(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom), 1'b0, none);
         end
      end
   endtask

   // ---------------------------------------------------------------- main flow

   initial begin
      // defaults after reset: interval zero, so done holds from the start
      dir_table.push_back(dr(1, REQ_LOAD,  63, 0, 63, 0, 'hFFFF, 0,      0, 0, 1, 0));
      dir_table.push_back(dr(1, REQ_READ,  63, 0, 63, 0, 0,      'hFFFF, 0, 0, 1, 0));
      dir_table.push_back(dr(1, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 1, 0));
      dir_table.push_back(dr(1, REQ_CLEAR, 0,  0, 0,  0, 0,      0,      0, 0, 1, 0));
      // 40 x 50 in use, interval 5: diagonal swap, then anti swap back
      dir_table.push_back(dr(0, REQ_LOAD,  0,  0, 0,  0, 5,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  1,  0, 1,  0, 7,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  0,  0, 1,  0, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  1,  0, 0,  0, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_READ,  1,  0, 0,  0, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 0, 0));
      // equal rows, equal columns, indices past the rows and columns in use
      dir_table.push_back(dr(1, REQ_SWAP,  1,  1, 0,  1, 0,      0,      0, 1, 0, 2));
      dir_table.push_back(dr(1, REQ_SWAP,  0,  1, 1,  1, 0,      0,      0, 1, 0, 2));
      dir_table.push_back(dr(1, REQ_SWAP,  0, 63, 0,  1, 0,      0,      0, 1, 0, 2));
      dir_table.push_back(dr(1, REQ_SWAP,  0,  1, 0, 63, 0,      0,      0, 1, 0, 2));
      dir_table.push_back(dr(1, REQ_LOAD,  63, 0, 0,  0, 'h1234, 0,      0, 1, 0, 2));
      dir_table.push_back(dr(1, REQ_READ,  0,  0, 63, 0, 0,      0,      0, 1, 0, 2));
      // no checkerboard: counted in trial mode, nothing moves
      dir_table.push_back(dr(0, REQ_LOAD,  2,  0, 2,  0, 3,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  2,  0, 3,  0, 3,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  3,  0, 2,  0, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_LOAD,  3,  0, 3,  0, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_SWAP,  2,  3, 2,  3, 0,      0,      0, 0, 0, 0));
      // run up to done, then an attempt that is dropped, then clear
      dir_table.push_back(dr(0, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(0, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 0, 0));
      dir_table.push_back(dr(1, REQ_SWAP,  0,  1, 0,  1, 0,      0,      0, 0, 1, 5));
      dir_table.push_back(dr(1, REQ_CLEAR, 0,  0, 0,  0, 0,      0,      0, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < dir_table.size(); k++) begin
         if (k == 4)
            set_config(1'b0, 5, 40, 50);
         send_beat(dir_table[k].beat, dir_table[k].pin, dir_table[k].want);
      end

      // random phases; the counter carries across them unless cleared
      set_config(1'b0, 20'hFFFFF, 64, 64);
      run_random(150);
      set_config(1'b1, 40, 2, 2);
      run_random(120);
      set_config(1'b0, 5, 64, 2);
      run_random(100);
      set_config(1'b1, 0, 16, 16);
      run_random(60);
      set_config(1'b0, $urandom_range(20, 200), $urandom_range(2, 64), $urandom_range(2, 64));
      run_random(170);
      set_config(1'b1, 1000, 8, 5);
      run_random(150);

      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("checkerboard_swap_engine_core_tb: done, clean");
      else
         $display("checkerboard_swap_engine_core_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
